>>> src/drp_pkg.sv
// Shared types, widths and ROM tables for the drag Reynolds product interpolator.
package drp_pkg;

    localparam int TABLE_POINTS = 34;
    localparam int SEGMENTS     = TABLE_POINTS - 1;
    localparam int SEG_W        = $clog2(SEGMENTS);

    localparam int IN_W      = 22;
    localparam int OUT_W     = 26;
    localparam int REGION_W  = 2;
    localparam int CD_W      = 20;
    localparam int SLOPE_W   = 26;
    localparam int CD_FRAC   = 16;
    localparam int OFS_W     = IN_W + 1;
    localparam int PROD1_W   = SLOPE_W + OFS_W;
    localparam int QUOT_W    = PROD1_W - CD_FRAC;
    localparam int CD_SUM_W  = QUOT_W + 2;
    localparam int CD_SAT_W  = 24;
    localparam int PROD2_W   = CD_SAT_W + IN_W;
    localparam int SCALED_W  = PROD2_W + 1 - CD_FRAC;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 3;

    localparam int QDEPTH = 4;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    localparam logic [REGION_W-1:0] REGION_BELOW  = 2'd0;
    localparam logic [REGION_W-1:0] REGION_INSIDE = 2'd1;
    localparam logic [REGION_W-1:0] REGION_ABOVE  = 2'd2;

    typedef struct packed {
        logic [IN_W-1:0]     reynolds;
        logic [SEG_W-1:0]    seg;
        logic [REGION_W-1:0] region;
    } drp_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } drp_qstat_t;

    localparam logic [IN_W-1:0] BP_Q [TABLE_POINTS] = '{
        22'd461,    22'd2460,   22'd5990,   22'd11059,  22'd17587,  22'd25318,
        22'd34304,  22'd44800,  22'd56320,  22'd68864,  22'd95232,  22'd123648,
        22'd154368, 22'd187136, 22'd221696, 22'd259328, 22'd297984, 22'd336128,
        22'd374016, 22'd412928, 22'd451584, 22'd490240, 22'd528896, 22'd566016,
        22'd603392, 22'd640000, 22'd674816, 22'd709632, 22'd743680, 22'd776448,
        22'd809984, 22'd843008, 22'd876288, 22'd908544
    };

    localparam logic [CD_W-1:0] CD_Q [TABLE_POINTS] = '{
        20'd983040, 20'd275251, 20'd157286, 20'd108790, 20'd83886,  20'd70124,
        20'd60686,  20'd53412,  20'd47776,  20'd43975,  20'd39780,  20'd37356,
        20'd35717,  20'd34603,  20'd33882,  20'd33030,  20'd32440,  20'd32375,
        20'd32637,  20'd32965,  20'd33489,  20'd34079,  20'd34669,  20'd35652,
        20'd36635,  20'd37683,  20'd38928,  20'd40305,  20'd41615,  20'd43254,
        20'd44630,  20'd45875,  20'd47645,  20'd49218
    };

    // Coefficient change per input LSB, Q.16 scaled by 2^16, rounded half away from zero.
    localparam logic signed [SLOPE_W-1:0] SLOPE_Q [SEGMENTS] = '{
        SLOPE_W'(-((64'sd707789 * 131072 + 1999) / (2 * 1999))),
        SLOPE_W'(-((64'sd117965 * 131072 + 3530) / (2 * 3530))),
        SLOPE_W'(-((64'sd48496 * 131072 + 5069) / (2 * 5069))),
        SLOPE_W'(-((64'sd24904 * 131072 + 6528) / (2 * 6528))),
        SLOPE_W'(-((64'sd13762 * 131072 + 7731) / (2 * 7731))),
        SLOPE_W'(-((64'sd9438 * 131072 + 8986) / (2 * 8986))),
        SLOPE_W'(-((64'sd7274 * 131072 + 10496) / (2 * 10496))),
        SLOPE_W'(-((64'sd5636 * 131072 + 11520) / (2 * 11520))),
        SLOPE_W'(-((64'sd3801 * 131072 + 12544) / (2 * 12544))),
        SLOPE_W'(-((64'sd4195 * 131072 + 26368) / (2 * 26368))),
        SLOPE_W'(-((64'sd2424 * 131072 + 28416) / (2 * 28416))),
        SLOPE_W'(-((64'sd1639 * 131072 + 30720) / (2 * 30720))),
        SLOPE_W'(-((64'sd1114 * 131072 + 32768) / (2 * 32768))),
        SLOPE_W'(-((64'sd721 * 131072 + 34560) / (2 * 34560))),
        SLOPE_W'(-((64'sd852 * 131072 + 37632) / (2 * 37632))),
        SLOPE_W'(-((64'sd590 * 131072 + 38656) / (2 * 38656))),
        SLOPE_W'(-((64'sd65 * 131072 + 38144) / (2 * 38144))),
        SLOPE_W'((64'sd262 * 131072 + 37888) / (2 * 37888)),
        SLOPE_W'((64'sd328 * 131072 + 38912) / (2 * 38912)),
        SLOPE_W'((64'sd524 * 131072 + 38656) / (2 * 38656)),
        SLOPE_W'((64'sd590 * 131072 + 38656) / (2 * 38656)),
        SLOPE_W'((64'sd590 * 131072 + 38656) / (2 * 38656)),
        SLOPE_W'((64'sd983 * 131072 + 37120) / (2 * 37120)),
        SLOPE_W'((64'sd983 * 131072 + 37376) / (2 * 37376)),
        SLOPE_W'((64'sd1048 * 131072 + 36608) / (2 * 36608)),
        SLOPE_W'((64'sd1245 * 131072 + 34816) / (2 * 34816)),
        SLOPE_W'((64'sd1377 * 131072 + 34816) / (2 * 34816)),
        SLOPE_W'((64'sd1310 * 131072 + 34048) / (2 * 34048)),
        SLOPE_W'((64'sd1639 * 131072 + 32768) / (2 * 32768)),
        SLOPE_W'((64'sd1376 * 131072 + 33536) / (2 * 33536)),
        SLOPE_W'((64'sd1245 * 131072 + 33024) / (2 * 33024)),
        SLOPE_W'((64'sd1770 * 131072 + 33280) / (2 * 33280)),
        SLOPE_W'((64'sd1573 * 131072 + 32256) / (2 * 32256))
    };

endpackage

>>> src/drp_front.sv
// Front end: accepts input transfers and classifies each value into a table segment.
module drp_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [drp_pkg::S_TDATA_W-1:0]  s_tdata,   // [21:0] reynolds
    input  drp_pkg::drp_qstat_t            qstat,
    output logic                           q_push,
    output drp_pkg::drp_item_t             q_item
);
    import drp_pkg::*;

    logic [IN_W-1:0]         value;
    logic [TABLE_POINTS-1:0] ge;
    logic [SEG_W-1:0]        seg_hit;

    always_comb begin
        value = s_tdata[IN_W-1:0];
        for (int k = 0; k < TABLE_POINTS; k++) begin
            ge[k] = (value >= BP_Q[k]);
        end
        seg_hit = '0;
        for (int k = 0; k < SEGMENTS; k++) begin
            if (ge[k] && !ge[k+1]) begin
                seg_hit = seg_hit | SEG_W'(k);
            end
        end
        q_item.reynolds = value;
        priority if (!ge[0]) begin
            q_item.seg    = '0;
            q_item.region = REGION_BELOW;
        end else if (ge[TABLE_POINTS-1]) begin
            q_item.seg    = SEG_W'(SEGMENTS - 1);
            q_item.region = REGION_ABOVE;
        end else begin
            q_item.seg    = seg_hit;
            q_item.region = REGION_INSIDE;
        end
    end

    assign s_tready = !qstat.full;
    assign q_push   = s_tvalid && !qstat.full;

endmodule

>>> src/drp_queue.sv
// Short queue of classified items between the front end and the arithmetic pipeline.
module drp_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  drp_pkg::drp_item_t  push_item,
    input  logic                pop,
    output drp_pkg::drp_item_t  pop_item,
    output drp_pkg::drp_qstat_t qstat
);
    import drp_pkg::*;

    drp_item_t        mem [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb begin
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item    = mem[rd_ptr_reg];
    assign qstat.full  = (count_reg == CNT_W'(QDEPTH));
    assign qstat.empty = (count_reg == '0);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count lost a push");

endmodule

>>> src/drp_back.sv
// Back end: interpolates the coefficient, forms the product, rounds and saturates.
module drp_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  drp_pkg::drp_qstat_t            qstat,
    input  drp_pkg::drp_item_t             q_item,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [drp_pkg::M_TDATA_W-1:0]  m_tdata,   // [25:0] drag_times_re
    output logic [drp_pkg::M_TUSER_W-1:0]  m_tuser    // [1:0] region, [2] saturated
);
    import drp_pkg::*;

    localparam logic [PROD1_W-1:0] HALF1 = PROD1_W'(2 ** (CD_FRAC - 1));
    localparam logic [PROD2_W:0]   HALF2 = (PROD2_W + 1)'(2 ** (CD_FRAC - 1));

    logic advance;

    logic                       s1_valid_reg;
    logic signed [PROD1_W-1:0]  s1_prod_reg;
    logic signed [PROD1_W-1:0]  s1_prod_next;
    logic [CD_W-1:0]            s1_cd_reg;
    logic [IN_W-1:0]            s1_v_reg;
    logic [REGION_W-1:0]        s1_region_reg;

    logic                       s2_valid_reg;
    logic [CD_SAT_W-1:0]        s2_cd_reg;
    logic [CD_SAT_W-1:0]        s2_cd_next;
    logic [IN_W-1:0]            s2_v_reg;
    logic [REGION_W-1:0]        s2_region_reg;

    logic                       s3_valid_reg;
    logic [PROD2_W-1:0]         s3_prod_reg;
    logic [PROD2_W-1:0]         s3_prod_next;
    logic [REGION_W-1:0]        s3_region_reg;

    logic                       out_valid_reg;
    logic [OUT_W-1:0]           out_drag_reg;
    logic [OUT_W-1:0]           out_drag_next;
    logic [REGION_W-1:0]        out_region_reg;
    logic                       out_sat_reg;
    logic                       out_sat_next;

    logic [IN_W-1:0]            bp;
    logic signed [SLOPE_W-1:0]  slope;
    logic signed [OFS_W-1:0]    offset;
    logic                       neg;
    logic [PROD1_W-1:0]         mag;
    logic [PROD1_W-1:0]         mag_rnd;
    logic [QUOT_W-1:0]          quot;
    logic signed [QUOT_W:0]     corr;
    logic signed [CD_SUM_W-1:0] cd_sum;
    logic [PROD2_W:0]           prod_rnd;
    logic [SCALED_W-1:0]        scaled;

    assign advance = !out_valid_reg || m_tready;
    assign q_pop   = advance && !qstat.empty;

    always_comb begin
        bp     = BP_Q[q_item.seg];
        slope  = SLOPE_Q[q_item.seg];
        offset = $signed({1'b0, q_item.reynolds}) - $signed({1'b0, bp});
        s1_prod_next = PROD1_W'(slope) * PROD1_W'(offset);
    end

    always_comb begin
        neg     = s1_prod_reg[PROD1_W-1];
        mag     = neg ? PROD1_W'(-s1_prod_reg) : PROD1_W'(s1_prod_reg);
        mag_rnd = mag + HALF1;
        quot    = mag_rnd[PROD1_W-1:CD_FRAC];
        corr    = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
        cd_sum  = CD_SUM_W'($signed({1'b0, s1_cd_reg})) + CD_SUM_W'(corr);
        priority if (cd_sum[CD_SUM_W-1]) begin
            s2_cd_next = '0;
        end else if (|cd_sum[CD_SUM_W-2:CD_SAT_W]) begin
            s2_cd_next = '1;
        end else begin
            s2_cd_next = cd_sum[CD_SAT_W-1:0];
        end
    end

    always_comb begin
        s3_prod_next = PROD2_W'(s2_cd_reg) * PROD2_W'(s2_v_reg);
    end

    always_comb begin
        prod_rnd      = (PROD2_W + 1)'(s3_prod_reg) + HALF2;
        scaled        = prod_rnd[PROD2_W:CD_FRAC];
        out_sat_next  = |scaled[SCALED_W-1:OUT_W];
        out_drag_next = out_sat_next ? '1 : scaled[OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg  <= q_pop;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_prod_reg    <= s1_prod_next;
            s1_cd_reg      <= CD_Q[q_item.seg];
            s1_v_reg       <= q_item.reynolds;
            s1_region_reg  <= q_item.region;
            s2_cd_reg      <= s2_cd_next;
            s2_v_reg       <= s1_v_reg;
            s2_region_reg  <= s1_region_reg;
            s3_prod_reg    <= s3_prod_next;
            s3_region_reg  <= s2_region_reg;
            out_drag_reg   <= out_drag_next;
            out_region_reg <= s3_region_reg;
            out_sat_reg    <= out_sat_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - OUT_W)'(0), out_drag_reg};
    assign m_tuser  = {out_sat_reg, out_region_reg};

    a_pop_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> s1_valid_reg)
        else $error("popped item did not enter the pipeline");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && s1_valid_reg) |=> s2_valid_reg)
        else $error("item dropped between interpolation stages");

endmodule

>>> src/drag_reynolds_product_interpolator.sv
// Top level of the drag coefficient times Reynolds number interpolator.
//
// Each input transfer carries one Reynolds number (22 bits, 8 fraction bits). The block
// places it in a 34-point breakpoint table, interpolates the drag coefficient linearly
// (extrapolating along the first segment below the table and along the last segment at or
// above it), multiplies by the input and returns the rounded product with 8 fraction bits,
// saturated at 2^26-1, together with the region code and a saturation flag in tuser.
// Sustained rate is one item per clock while m_tready stays high. Items pass through the
// queue and then the four-stage arithmetic pipeline (slope multiply, coefficient add and
// clamp, product multiply, round and saturate). A four-entry queue between the classifier
// and the pipeline absorbs output backpressure; s_tready drops only when it is full.
module drag_reynolds_product_interpolator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [drp_pkg::S_TDATA_W-1:0]  s_tdata,   // [21:0] reynolds
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [drp_pkg::M_TDATA_W-1:0]  m_tdata,   // [25:0] drag_times_re
    output logic [drp_pkg::M_TUSER_W-1:0]  m_tuser    // [1:0] region, [2] saturated
);
    import drp_pkg::*;

    drp_qstat_t qstat;
    drp_item_t  push_item;
    drp_item_t  pop_item;
    logic       push;
    logic       pop;

    drp_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .qstat    (qstat),
        .q_push   (push),
        .q_item   (push_item)
    );

    drp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .qstat     (qstat)
    );

    drp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .qstat    (qstat),
        .q_item   (pop_item),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> tb/sv/tb_drag_reynolds_product_interpolator.sv
// Testbench for the drag coefficient times Reynolds number interpolator.
`timescale 1ns / 100ps

typedef struct {
    logic [drp_pkg::OUT_W-1:0]    product;
    logic [drp_pkg::REGION_W-1:0] region;
    logic                         saturated;
} drag_result_t;

class drag_product_scoreboard;
    localparam int N = drp_pkg::TABLE_POINTS;
    localparam longint OUT_MAX = (64'd1 << drp_pkg::OUT_W) - 1;

    longint re_milli [N];
    longint cd_milli [N];
    longint bp_q     [N];
    longint cd_q     [N];
    longint slope_q  [N];
    drag_result_t expected_products [$];
    int mismatches;

    function new();
        longint dx, df;
        re_milli = '{1800, 9610, 23400, 43200, 68700, 98900, 134000,
                     175000, 220000, 269000, 372000, 483000, 603000, 731000,
                     866000, 1013000, 1164000, 1313000, 1461000, 1613000, 1764000,
                     1915000, 2066000, 2211000, 2357000, 2500000, 2636000, 2772000,
                     2905000, 3033000, 3164000, 3293000, 3423000, 3549000};
        cd_milli = '{15000, 4200, 2400, 1660, 1280, 1070, 926,
                     815, 729, 671, 607, 570, 545, 528,
                     517, 504, 495, 494, 498, 503, 511,
                     520, 529, 544, 559, 575, 594, 615,
                     635, 660, 681, 700, 727, 751};
        mismatches = 0;
        for (int k = 0; k < N; k++) begin
            bp_q[k] = (re_milli[k] * 256 + 500) / 1000;
            cd_q[k] = (cd_milli[k] * 65536 + 500) / 1000;
        end
        for (int k = 0; k < N; k++) begin
            slope_q[k] = 0;
            if (k + 1 < N) begin
                dx = bp_q[k + 1] - bp_q[k];
                df = cd_q[k + 1] - cd_q[k];
                if (dx > 0)
                    slope_q[k] = div_round(df * 65536, dx);
            end
        end
    endfunction

    // round half away from zero, d > 0
    function longint div_round(longint n, longint d);
        longint mag, q;
        mag = (n < 0) ? -n : n;
        q = (mag * 2 + d) / (2 * d);
        return (n < 0) ? -q : q;
    endfunction

    function drag_result_t predict_drag_product(logic [drp_pkg::IN_W-1:0] reynolds);
        drag_result_t r;
        longint x, cd, prod;
        int seg;
        x = longint'(reynolds);
        seg = 0;
        if (x < bp_q[0]) begin
            r.region = drp_pkg::REGION_BELOW;
        end else if (x >= bp_q[N-1]) begin
            seg = N - 2;
            r.region = drp_pkg::REGION_ABOVE;
        end else begin
            r.region = drp_pkg::REGION_INSIDE;
            for (int k = 0; k + 1 < N; k++)
                if (bp_q[k] <= x && x < bp_q[k + 1]) begin
                    seg = k;
                    break;
                end
        end
        cd = cd_q[seg] + div_round(slope_q[seg] * (x - bp_q[seg]), 65536);
        if (cd < 0)
            cd = 0;
        prod = (cd * x + 32768) >>> 16;
        r.saturated = 1'b0;
        if (prod > OUT_MAX) begin
            prod = OUT_MAX;
            r.saturated = 1'b1;
        end
        r.product = prod[drp_pkg::OUT_W-1:0];
        return r;
    endfunction

    function void note_reynolds(logic [drp_pkg::IN_W-1:0] reynolds);
        expected_products.push_back(predict_drag_product(reynolds));
    endfunction

    function int pending();
        return expected_products.size();
    endfunction

    task report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    task check_product(logic [drp_pkg::M_TDATA_W-1:0] tdata,
                       logic [drp_pkg::M_TUSER_W-1:0] tuser);
        drag_result_t want;
        if (expected_products.size() == 0) begin
            report_mismatch("unexpected transfer, drag_times_re", tdata[25:0], 0);
        end else begin
            want = expected_products.pop_front();
            if (tdata[25:0] !== want.product)
                report_mismatch("drag_times_re", tdata[25:0], want.product);
            if (tuser[1:0] !== want.region)
                report_mismatch("region", tuser[1:0], want.region);
            if (tuser[2] !== want.saturated)
                report_mismatch("saturated", tuser[2], want.saturated);
        end
    endtask
endclass

module tb_drag_reynolds_product_interpolator;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PHASE_ITEMS     = 420;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TAIL_CYCLES     = 16;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [drp_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [drp_pkg::M_TDATA_W-1:0] m_tdata;
    logic [drp_pkg::M_TUSER_W-1:0] m_tuser;

    drag_product_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int quiet_cycles   = 0;

    drag_reynolds_product_interpolator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_product(m_tdata, m_tuser);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("drag_reynolds_product_interpolator regression: fail");
                $finish;
            end else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // starts and ends at a falling edge
    task send_reynolds(logic [drp_pkg::IN_W-1:0] reynolds);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, reynolds};
        do @(posedge aclk); while (!s_tready);
        sb.note_reynolds(reynolds);
        @(negedge aclk);
    endtask

    task drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    function logic [drp_pkg::IN_W-1:0] random_reynolds();
        int k;
        longint v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom_range(drp_pkg::BP_Q[drp_pkg::TABLE_POINTS-1], 0);
            4, 5: begin
                k = $urandom_range(drp_pkg::TABLE_POINTS - 1);
                v = longint'(drp_pkg::BP_Q[k]) + $urandom_range(6) - 3;
                if (v < 0)
                    v = 0;
            end
            6, 7: v = $urandom & 32'h003F_FFFF;
            8: v = $urandom_range(drp_pkg::BP_Q[0] - 1, 0);
            default: v = $urandom_range(22'h3F_FFFF, drp_pkg::BP_Q[drp_pkg::TABLE_POINTS-1]);
        endcase
        return v[drp_pkg::IN_W-1:0];
    endfunction

    initial begin
        logic [drp_pkg::IN_W-1:0] directed [$];
        int idle_pcts  [4];
        int stall_pcts [4];
        idle_pcts  = '{0, 80, 0, 31};
        stall_pcts = '{0, 0, 80, 31};
        directed = '{22'd0, 22'd1, 22'd230, 22'd460, 22'd461, 22'd462, 22'd2459,
                     22'd2460, 22'd5990, 22'd11059, 22'd56320, 22'd454000,
                     22'd876287, 22'd876288, 22'd908543, 22'd908544, 22'd908545,
                     22'h3F_FFFF, 22'h2A_AAAA, 22'h15_5555, 22'h20_0000};
        sb = new();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[i])
            send_reynolds(directed[i]);

        // fill the block while the receiver holds off
        hold_request = HOLD_OFF_CYCLES;
        repeat (40)
            send_reynolds(random_reynolds());
        drain_results();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_pcts[p];
            recv_stall_pct = stall_pcts[p];
            repeat (PHASE_ITEMS)
                send_reynolds(random_reynolds());
            drain_results();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("drag_reynolds_product_interpolator regression: pass");
        else
            $display("drag_reynolds_product_interpolator regression: fail");
        $finish;
    end
endmodule
